// ----- hdl/wsptr_pkg.sv -----
// shared types and constants for the 2x2 window sum trigger
package wsptr_pkg;

  // default geometry and sample width
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 1024;
  localparam int ADC_BITS_DEF = 12;

  // window is WIN_COLS columns wide and two rows high
  localparam int WIN_COLS = 2;
  localparam int MIN_DIM  = 2;

  // result field widths
  localparam int PCOL_W  = 6;
  localparam int PROW_W  = 10;
  localparam int PSUM_W  = 14;
  localparam int TBITS_W = 8;

  // register widths
  localparam int THR_W      = 14;
  localparam int BITPOS_W   = 3;
  localparam int NCOLS_W    = 7;
  localparam int NROWS_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // result queue depth
  localparam int OFIFO_DEPTH = 4;

  // register reset values
  localparam logic [THR_W-1:0]    THR_HIGH_RST = '0;
  localparam logic [THR_W-1:0]    THR_LOW_RST  = '0;
  localparam logic [BITPOS_W-1:0] HIGH_POS_RST = 3'd1;
  localparam logic [BITPOS_W-1:0] LOW_POS_RST  = 3'd0;
  localparam logic [NCOLS_W-1:0]  NUM_COLS_RST = 7'd64;
  localparam logic [NROWS_W-1:0]  NUM_ROWS_RST = 11'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_HIGH = 3'd0,
    CFG_THR_LOW  = 3'd1,
    CFG_HIGH_POS = 3'd2,
    CFG_LOW_POS  = 3'd3,
    CFG_NUM_COLS = 3'd4,
    CFG_NUM_ROWS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [PCOL_W-1:0]  col;
    logic [PROW_W-1:0]  row;
    logic [PSUM_W-1:0]  sum;
    logic [TBITS_W-1:0] bits;
  } patch_t;

endpackage

// ----- hdl/window_sum_patch_trigger_top.sv -----
// 2x2 window sum trigger: line buffer, chain of window column cells, result queue
// a completed window is compared from the registered window cells and pushed into the result queue, which drives out_*
// throughput: one pixel per cycle while in_ready is high, set by the single-write line buffer and the window cell shift
// in_ready drops only when the result queue plus the compare stage could overflow
// reset (synchronous, rst_n low) clears counters, window cells, queue and registers to defaults
// the line buffer is not cleared; each entry is written during row 0 before it is read
module window_sum_patch_trigger_top #(
  parameter int MAX_COLS = wsptr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = wsptr_pkg::MAX_ROWS_DEF,
  parameter int ADC_BITS = wsptr_pkg::ADC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ADC_BITS-1:0]              in_adc,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wsptr_pkg::PCOL_W-1:0]     out_patch_col,
  output logic [wsptr_pkg::PROW_W-1:0]     out_patch_row,
  output logic [wsptr_pkg::PSUM_W-1:0]     out_patch_sum,
  output logic [wsptr_pkg::TBITS_W-1:0]    out_trigger_bits,
  input  logic                             cfg_wr_en,
  input  logic [wsptr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsptr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CCW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW   = (CCW + 1 > wsptr_pkg::NCOLS_W) ? CCW + 1 : wsptr_pkg::NCOLS_W;
  localparam int RLW   = (RCW + 1 > wsptr_pkg::NROWS_W) ? RCW + 1 : wsptr_pkg::NROWS_W;
  localparam int WIN   = wsptr_pkg::WIN_COLS;
  localparam int SW    = ADC_BITS + $clog2(2 * WIN);
  localparam int THW   = wsptr_pkg::THR_W;
  localparam int SCW   = (SW > THW) ? SW : THW;
  localparam int PCW   = wsptr_pkg::PCOL_W;
  localparam int PRW   = wsptr_pkg::PROW_W;
  localparam int PSW   = wsptr_pkg::PSUM_W;
  localparam int TBW   = wsptr_pkg::TBITS_W;
  localparam int BPW   = wsptr_pkg::BITPOS_W;
  localparam int NCW   = wsptr_pkg::NCOLS_W;
  localparam int NRW   = wsptr_pkg::NROWS_W;
  localparam int DEPTH = wsptr_pkg::OFIFO_DEPTH;
  localparam int FCW   = $clog2(DEPTH+1);

  // configuration registers
  logic [THW-1:0] thr_high_r;
  logic [THW-1:0] thr_low_r;
  logic [BPW-1:0] high_pos_r;
  logic [BPW-1:0] low_pos_r;
  logic [NCW-1:0] num_cols_r;
  logic [NRW-1:0] num_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_high_r <= wsptr_pkg::THR_HIGH_RST;
      thr_low_r  <= wsptr_pkg::THR_LOW_RST;
      high_pos_r <= wsptr_pkg::HIGH_POS_RST;
      low_pos_r  <= wsptr_pkg::LOW_POS_RST;
      num_cols_r <= wsptr_pkg::NUM_COLS_RST;
      num_rows_r <= wsptr_pkg::NUM_ROWS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wsptr_pkg::CFG_THR_HIGH: thr_high_r <= cfg_data[THW-1:0];
        wsptr_pkg::CFG_THR_LOW:  thr_low_r  <= cfg_data[THW-1:0];
        wsptr_pkg::CFG_HIGH_POS: high_pos_r <= cfg_data[BPW-1:0];
        wsptr_pkg::CFG_LOW_POS:  low_pos_r  <= cfg_data[BPW-1:0];
        wsptr_pkg::CFG_NUM_COLS: num_cols_r <= cfg_data[NCW-1:0];
        wsptr_pkg::CFG_NUM_ROWS: num_rows_r <= cfg_data[NRW-1:0];
        default: ;
      endcase
    end
  end

  // geometry, saturated into the supported range
  logic [CLW-1:0] ncols_e, cols_c;
  logic [RLW-1:0] nrows_e, rows_c;

  always_comb begin
    ncols_e = CLW'(num_cols_r);
    nrows_e = RLW'(num_rows_r);
    if (ncols_e < CLW'(wsptr_pkg::MIN_DIM)) begin
      cols_c = CLW'(wsptr_pkg::MIN_DIM);
    end else if (ncols_e > CLW'(MAX_COLS)) begin
      cols_c = CLW'(MAX_COLS);
    end else begin
      cols_c = ncols_e;
    end
    if (nrows_e < RLW'(wsptr_pkg::MIN_DIM)) begin
      rows_c = RLW'(wsptr_pkg::MIN_DIM);
    end else if (nrows_e > RLW'(MAX_ROWS)) begin
      rows_c = RLW'(MAX_ROWS);
    end else begin
      rows_c = nrows_e;
    end
  end

  // position tracking
  logic [CCW-1:0] col_count_r, col_count_nxt;
  logic [RCW-1:0] row_count_r, row_count_nxt;
  logic           frame_done_r, frame_done_nxt;
  logic           in_acc, proc;
  logic [CCW-1:0] cur_c;
  logic [RCW-1:0] cur_r;
  logic           cur_done;
  logic [CLW-1:0] col_inc;
  logic [RLW-1:0] row_inc;
  logic           wrap_c, wrap_r;

  assign in_acc   = in_valid && in_ready;
  assign cur_c    = in_frame_start ? '0 : col_count_r;
  assign cur_r    = in_frame_start ? '0 : row_count_r;
  assign cur_done = in_frame_start ? 1'b0 : frame_done_r;
  assign proc     = in_acc && !cur_done;
  assign col_inc  = CLW'(cur_c) + CLW'(1);
  assign row_inc  = RLW'(cur_r) + RLW'(1);
  assign wrap_c   = (col_inc >= cols_c);
  assign wrap_r   = (row_inc >= rows_c);

  always_comb begin
    col_count_nxt  = col_count_r;
    row_count_nxt  = row_count_r;
    frame_done_nxt = frame_done_r;
    if (proc) begin
      if (wrap_c) begin
        col_count_nxt = '0;
        if (wrap_r) begin
          row_count_nxt  = '0;
          frame_done_nxt = 1'b1;
        end else begin
          row_count_nxt  = RCW'(row_inc);
          frame_done_nxt = 1'b0;
        end
      end else begin
        col_count_nxt  = CCW'(col_inc);
        row_count_nxt  = cur_r;
        frame_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r  <= '0;
      row_count_r  <= '0;
      frame_done_r <= 1'b0;
    end else begin
      col_count_r  <= col_count_nxt;
      row_count_r  <= row_count_nxt;
      frame_done_r <= frame_done_nxt;
    end
  end

  // line buffer: registered reads at the next column and at column zero,
  // with bypass when the same entry is written in the same cycle
  logic [ADC_BITS-1:0] line_mem [MAX_COLS];
  logic [ADC_BITS-1:0] above_r;
  logic [ADC_BITS-1:0] above0_r;
  logic [ADC_BITS-1:0] above;

  always_ff @(posedge clk) begin
    if (proc) begin
      line_mem[cur_c] <= in_adc;
    end
    if (proc && (cur_c == col_count_nxt)) begin
      above_r <= in_adc;
    end else begin
      above_r <= line_mem[col_count_nxt];
    end
    if (proc && (cur_c == '0)) begin
      above0_r <= in_adc;
    end else begin
      above0_r <= line_mem[0];
    end
  end

  assign above = in_frame_start ? above0_r : above_r;

  // chain of window column cells, newest column in cell 0
  logic [ADC_BITS-1:0] cell_top [WIN];
  logic [ADC_BITS-1:0] cell_bot [WIN];
  logic [ADC_BITS:0]   cell_sum [WIN];

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    if (k == 0) begin : g_head
      wsptr_cell #(.DW(ADC_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (proc),
        .top_in   (above),
        .bot_in   (in_adc),
        .top_q    (cell_top[k]),
        .bot_q    (cell_bot[k]),
        .col_sum  (cell_sum[k])
      );
    end else begin : g_link
      wsptr_cell #(.DW(ADC_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (proc),
        .top_in   (cell_top[k-1]),
        .bot_in   (cell_bot[k-1]),
        .top_q    (cell_top[k]),
        .bot_q    (cell_bot[k]),
        .col_sum  (cell_sum[k])
      );
    end
  end

  // position of the window that the cells now hold
  logic           s1_valid_r;
  logic           s1_win_r;
  logic [PCW-1:0] s1_col_r;
  logic [PRW-1:0] s1_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      s1_win_r <= (cur_c != '0) && (cur_r != '0);
      s1_col_r <= PCW'(cur_c - CCW'(1));
      s1_row_r <= PRW'(cur_r - RCW'(1));
    end
  end

  // window sum and threshold compare
  logic [SW-1:0]     win_sum;
  logic [SCW-1:0]    sum_e;
  logic [TBW-1:0]    bits;
  logic              emit;
  wsptr_pkg::patch_t push_data;

  always_comb begin
    win_sum = '0;
    for (int k = 0; k < WIN; k++) begin
      win_sum = win_sum + SW'(cell_sum[k]);
    end
    sum_e = SCW'(win_sum);
    bits  = '0;
    if (sum_e > SCW'(thr_high_r)) begin
      bits[high_pos_r] = 1'b1;
    end
    if (sum_e > SCW'(thr_low_r)) begin
      bits[low_pos_r] = 1'b1;
    end
  end

  assign emit           = s1_valid_r && s1_win_r && (bits != '0);
  assign push_data.col  = s1_col_r;
  assign push_data.row  = s1_row_r;
  assign push_data.sum  = PSW'(win_sum);
  assign push_data.bits = bits;

  // result queue
  wsptr_pkg::patch_t head;
  logic [FCW-1:0]    fifo_count;
  logic [FCW:0]      occupancy;

  wsptr_ofifo #(.DEPTH(DEPTH)) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (push_data),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (head),
    .count     (fifo_count)
  );

  // room for the queued results, the one in the compare stage and a new one
  assign occupancy = (FCW+1)'(fifo_count) + (FCW+1)'(s1_valid_r);
  assign in_ready  = (occupancy < (FCW+1)'(DEPTH));

  assign out_patch_col    = head.col;
  assign out_patch_row    = head.row;
  assign out_patch_sum    = head.sum;
  assign out_trigger_bits = head.bits;

endmodule

// ----- hdl/wsptr_cell.sv -----
// one window column cell: holds the above/current pixel pair and its column sum
module wsptr_cell #(
  parameter int DW = wsptr_pkg::ADC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  logic [DW-1:0] top_in,
  input  logic [DW-1:0] bot_in,
  output logic [DW-1:0] top_q,
  output logic [DW-1:0] bot_q,
  output logic [DW:0]   col_sum
);

  logic [DW-1:0] top_r;
  logic [DW-1:0] bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      bot_r <= '0;
    end else if (shift_en) begin
      top_r <= top_in;
      bot_r <= bot_in;
    end
  end

  assign top_q   = top_r;
  assign bot_q   = bot_r;
  assign col_sum = {1'b0, top_r} + {1'b0, bot_r};

endmodule

// ----- hdl/wsptr_ofifo.sv -----
// small result queue between the window pipeline and the output channel
module wsptr_ofifo #(
  parameter int DEPTH = wsptr_pkg::OFIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  wsptr_pkg::patch_t          push_data,
  input  logic                       pop,
  output logic                       not_empty,
  output wsptr_pkg::patch_t          head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  wsptr_pkg::patch_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign count     = count_r;

endmodule

// ----- tb/window_sum_checker.sv -----
// checker for the 2x2 window sum trigger: predicts triggered windows and compares results
`timescale 1ns / 100ps
module window_sum_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [wsptr_pkg::ADC_BITS_DEF-1:0] in_adc,
  input  logic                               in_frame_start,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [wsptr_pkg::PCOL_W-1:0]       out_patch_col,
  input  logic [wsptr_pkg::PROW_W-1:0]       out_patch_row,
  input  logic [wsptr_pkg::PSUM_W-1:0]       out_patch_sum,
  input  logic [wsptr_pkg::TBITS_W-1:0]      out_trigger_bits,
  input  logic                               cfg_wr_en,
  input  logic [wsptr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsptr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                 mismatches,
  output int                                 windows_waiting,
  output int                                 windows_seen
);

  localparam int ADC_W       = wsptr_pkg::ADC_BITS_DEF;
  localparam int MAX_REPORTS = 10;
  localparam int MAXC        = wsptr_pkg::MAX_COLS_DEF;
  localparam int MAXR        = wsptr_pkg::MAX_ROWS_DEF;
  localparam int MIND        = wsptr_pkg::MIN_DIM;
  localparam int PCW         = wsptr_pkg::PCOL_W;
  localparam int PRW         = wsptr_pkg::PROW_W;
  localparam int PSW         = wsptr_pkg::PSUM_W;
  localparam int TBW         = wsptr_pkg::TBITS_W;
  localparam int THW         = wsptr_pkg::THR_W;
  localparam int BPW         = wsptr_pkg::BITPOS_W;
  localparam int NCW         = wsptr_pkg::NCOLS_W;
  localparam int NRW         = wsptr_pkg::NROWS_W;

  logic [THW-1:0] thr_high;
  logic [THW-1:0] thr_low;
  logic [BPW-1:0] high_pos;
  logic [BPW-1:0] low_pos;
  logic [NCW-1:0] num_cols;
  logic [NRW-1:0] num_rows;

  logic [ADC_W-1:0] row_above [MAXC];
  logic [ADC_W-1:0] left_pix;
  logic [ADC_W-1:0] left_above_pix;
  int unsigned      col_pos;
  int unsigned      row_pos;
  bit               frame_over;

  wsptr_pkg::patch_t triggered_windows[$];

  task automatic predict_window(input logic [ADC_W-1:0] adc, input logic fs);
    int unsigned       cols;
    int unsigned       rows;
    int unsigned       c;
    logic [ADC_W-1:0]  above;
    logic [PSW-1:0]    sum;
    logic [TBW-1:0]    bits;
    wsptr_pkg::patch_t win;
    cols = (num_cols < MIND) ? MIND :
           (num_cols > MAXC) ? MAXC : num_cols;
    rows = (num_rows < MIND) ? MIND :
           (num_rows > MAXR) ? MAXR : num_rows;
    if (fs) begin
      col_pos    = 0;
      row_pos    = 0;
      frame_over = 1'b0;
    end
    // pixels past the last row are dropped until the next frame start
    if (!frame_over) begin
      c     = (col_pos >= MAXC) ? MAXC - 1 : col_pos;
      above = row_above[c];
      if (row_pos >= 1 && c >= 1) begin
        sum  = PSW'(left_above_pix) + PSW'(above) + PSW'(left_pix) + PSW'(adc);
        bits = '0;
        if (sum > thr_high) bits[high_pos] = 1'b1;
        if (sum > thr_low) bits[low_pos] = 1'b1;
        if (bits != '0) begin
          win.col  = PCW'(c - 1);
          win.row  = PRW'(row_pos - 1);
          win.sum  = sum;
          win.bits = bits;
          triggered_windows.insert(triggered_windows.size(), win);
        end
      end
      left_above_pix = above;
      left_pix       = adc;
      row_above[c]   = adc;
      // a column count already past a shrunken row width wraps right away
      if (col_pos + 1 >= cols) begin
        col_pos = 0;
        if (row_pos + 1 >= rows) begin
          row_pos    = 0;
          frame_over = 1'b1;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    end
  endtask

  always @(posedge clk) begin
    wsptr_pkg::patch_t want;
    if (!rst_n) begin
      thr_high       = wsptr_pkg::THR_HIGH_RST;
      thr_low        = wsptr_pkg::THR_LOW_RST;
      high_pos       = wsptr_pkg::HIGH_POS_RST;
      low_pos        = wsptr_pkg::LOW_POS_RST;
      num_cols       = wsptr_pkg::NUM_COLS_RST;
      num_rows       = wsptr_pkg::NUM_ROWS_RST;
      left_pix       = '0;
      left_above_pix = '0;
      col_pos        = 0;
      row_pos        = 0;
      frame_over     = 1'b0;
      mismatches     = 0;
      windows_seen   = 0;
      triggered_windows.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          wsptr_pkg::CFG_THR_HIGH: thr_high = cfg_data[THW-1:0];
          wsptr_pkg::CFG_THR_LOW:  thr_low  = cfg_data[THW-1:0];
          wsptr_pkg::CFG_HIGH_POS: high_pos = cfg_data[BPW-1:0];
          wsptr_pkg::CFG_LOW_POS:  low_pos  = cfg_data[BPW-1:0];
          wsptr_pkg::CFG_NUM_COLS: num_cols = cfg_data[NCW-1:0];
          wsptr_pkg::CFG_NUM_ROWS: num_rows = cfg_data[NRW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_window(in_adc, in_frame_start);
      if (out_valid && out_ready) begin
        if (triggered_windows.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected window: col %0d row %0d sum %0d bits %h",
                     out_patch_col, out_patch_row, out_patch_sum, out_trigger_bits);
          mismatches++;
        end else begin
          want = triggered_windows.pop_front();
          if (out_patch_col !== want.col || out_patch_row !== want.row ||
              out_patch_sum !== want.sum || out_trigger_bits !== want.bits) begin
            if (mismatches < MAX_REPORTS)
              $display("window %0d mismatch: expected col %0d row %0d sum %0d bits %h, %s",
                       windows_seen, want.col, want.row, want.sum, want.bits,
                       $sformatf("got col %0d row %0d sum %0d bits %h", out_patch_col,
                                 out_patch_row, out_patch_sum, out_trigger_bits));
            mismatches++;
          end
        end
        windows_seen++;
      end
    end
    windows_waiting = triggered_windows.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench top for the 2x2 window sum trigger: clock, reset, pixel stimulus and verdict
`timescale 1ns / 100ps
module tb_top;

  localparam int ADC_W          = wsptr_pkg::ADC_BITS_DEF;
  localparam int PCW            = wsptr_pkg::PCOL_W;
  localparam int PRW            = wsptr_pkg::PROW_W;
  localparam int PSW            = wsptr_pkg::PSUM_W;
  localparam int TBW            = wsptr_pkg::TBITS_W;
  localparam int CDW            = wsptr_pkg::CFG_DATA_W;
  localparam int THW            = wsptr_pkg::THR_W;
  localparam int BPW            = wsptr_pkg::BITPOS_W;
  localparam int NCW            = wsptr_pkg::NCOLS_W;
  localparam int NRW            = wsptr_pkg::NROWS_W;
  localparam int MAXC           = wsptr_pkg::MAX_COLS_DEF;
  localparam int MAXR           = wsptr_pkg::MAX_ROWS_DEF;
  localparam int MIND           = wsptr_pkg::MIN_DIM;
  localparam int MAX_GAP        = 30;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [ADC_W-1:0] ADC_FULL = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [ADC_W-1:0]      in_adc;
  logic                  in_frame_start;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PCW-1:0]        out_patch_col;
  logic [PRW-1:0]        out_patch_row;
  logic [PSW-1:0]        out_patch_sum;
  logic [TBW-1:0]        out_trigger_bits;
  logic                  cfg_wr_en;
  wsptr_pkg::cfg_idx_t   cfg_index;
  logic [CDW-1:0]        cfg_data;

  int mismatches;
  int windows_waiting;
  int windows_seen;
  int in_idle_pct;
  int out_stall_pct;
  int pixels_sent;
  int phases_run;
  int quiet_cycles = 0;

  window_sum_patch_trigger_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_adc           (in_adc),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_patch_col    (out_patch_col),
    .out_patch_row    (out_patch_row),
    .out_patch_sum    (out_patch_sum),
    .out_trigger_bits (out_trigger_bits),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  window_sum_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_adc           (in_adc),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_patch_col    (out_patch_col),
    .out_patch_row    (out_patch_row),
    .out_patch_sum    (out_patch_sum),
    .out_trigger_bits (out_trigger_bits),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .windows_waiting  (windows_waiting),
    .windows_seen     (windows_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ADC_W-1:0] pick_adc();
    case ($urandom_range(9))
      0: return '0;
      1: return ADC_FULL;
      2: return ADC_W'($urandom_range(0, 63));
      default: return ADC_W'($urandom);
    endcase
  endfunction

  // starts and ends on a falling edge; valid stays up when the next pixel follows at once
  task automatic send_pixel(input logic [ADC_W-1:0] adc, input logic fs);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_adc         <= adc;
    in_frame_start <= fs;
    do begin
      @(posedge clk);
    end while (!(in_valid && in_ready));
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic send_frame4(input logic [ADC_W-1:0] a, b, c, d);
    send_pixel(a, 1'b1);
    send_pixel(b, 1'b0);
    send_pixel(c, 1'b0);
    send_pixel(d, 1'b0);
  endtask

  // wait out every predicted window plus the pipeline, so registers change while idle
  task automatic drain();
    in_valid <= 1'b0;
    while (windows_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input wsptr_pkg::cfg_idx_t idx, input logic [CDW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // narrow registers get random junk above their width, which must be dropped
  task automatic program_regs(input logic [THW-1:0] th, tl,
                              input logic [BPW-1:0] hp, lp,
                              input logic [NCW-1:0] nc,
                              input logic [NRW-1:0] nr);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(wsptr_pkg::CFG_THR_HIGH, th);
    write_reg(wsptr_pkg::CFG_THR_LOW, tl);
    write_reg(wsptr_pkg::CFG_HIGH_POS, CDW'({junk, hp}));
    write_reg(wsptr_pkg::CFG_LOW_POS, CDW'({junk[31:9], lp}));
    write_reg(wsptr_pkg::CFG_NUM_COLS, CDW'({junk[31:4], nc}));
    write_reg(wsptr_pkg::CFG_NUM_ROWS, CDW'({junk[30:0], nr}));
    cfg_wr_en <= 1'b0;
  endtask

  // whole frames with random content, a few cut short and a few trailing ignored pixels
  task automatic run_random_phase(input int in_pct, out_pct, budget,
                                  input logic [NCW-1:0] nc,
                                  input logic [NRW-1:0] nr,
                                  input bit fresh);
    int eff_cols;
    int eff_rows;
    int frame_len;
    int pos;
    int counted;
    logic [BPW-1:0] lp;
    drain();
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    lp = BPW'($urandom_range(7));
    program_regs(THW'($urandom_range(16383)), THW'($urandom_range(12000)),
                 ($urandom_range(3) == 0) ? lp : BPW'($urandom_range(7)), lp, nc, nr);
    eff_cols  = (nc < MIND) ? MIND : (nc > MAXC) ? MAXC : nc;
    eff_rows  = (nr < MIND) ? MIND : (nr > MAXR) ? MAXR : nr;
    frame_len = eff_cols * eff_rows;
    pos       = fresh ? 0 : 1;
    counted   = 0;
    while (counted < budget) begin
      if (pos >= frame_len && $urandom_range(3) != 0) pos = 0;
      else if (pos > 0 && $urandom_range(199) == 0) pos = 0;
      send_pixel(pick_adc(), pos == 0);
      if (pos < frame_len) counted++;
      pos++;
    end
    phases_run++;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_adc         = '0;
    in_frame_start = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = wsptr_pkg::CFG_THR_HIGH;
    cfg_data       = '0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    pixels_sent    = 0;
    phases_run     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry and no frame start: these land in row 0
    send_pixel(ADC_FULL, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(ADC_W'('h555), 1'b0);

    // clamped 2x2 frames: full scale, past the last row, zero sum, sum equal to threshold
    drain();
    program_regs(THW'(100), '0, 3'd7, 3'd0, 7'd0, 11'd1);
    send_frame4(ADC_FULL, ADC_FULL, ADC_FULL, ADC_FULL);
    send_pixel(ADC_W'(123), 1'b0);
    send_frame4('0, '0, '0, '0);
    send_frame4(ADC_W'(25), ADC_W'(25), ADC_W'(25), ADC_W'(25));
    send_frame4(ADC_W'(25), ADC_W'(25), ADC_W'(25), ADC_W'(26));

    // thresholds at the top, both bits on one position
    drain();
    program_regs(THW'(16379), THW'(16383), 3'd3, 3'd3, 7'd1, 11'd0);
    send_frame4(ADC_FULL, ADC_FULL, ADC_FULL, ADC_FULL);

    run_random_phase(0, 0, 130, 7'd5, 11'd4, 1'b1);
    run_random_phase(76, 0, 200, 7'd127, 11'd3, 1'b1);
    // narrower rows mid-frame: the running column wraps to the next row
    run_random_phase(0, 76, 120, 7'd3, 11'd2047, 1'b0);
    run_random_phase(36, 36, 120, 7'd1, 11'd0, 1'b1);
    run_random_phase(0, 0, 90, 7'd7, 11'd5, 1'b1);
    run_random_phase(76, 0, 90, 7'd4, 11'd1024, 1'b1);
    run_random_phase(0, 76, 90, 7'd6, 11'd3, 1'b1);
    run_random_phase(36, 36, 90, 7'd2, 11'd3, 1'b0);
    drain();

    $display("run: %0d pixels, %0d random phases after directed frames, %0d windows compared",
             pixels_sent, phases_run, windows_seen);
    $display("run: clamped geometry, extreme thresholds, shared bit positions, mid-frame resize");
    if (mismatches == 0 && windows_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d windows never delivered", mismatches, windows_waiting);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
